FILE: hw/rtl/key_range_table_compactor_macros.svh
// assertion macros for the key range table block
`ifndef KEY_RANGE_TABLE_COMPACTOR_MACROS_SVH
`define KEY_RANGE_TABLE_COMPACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define KRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define KRT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KRT_ASSERT(label, clk, rst_n, prop)
`define KRT_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: hw/rtl/krtc_pkg.sv
// shared types and constants for the key range table block
`default_nettype none
package krtc_pkg;
    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int KEY_W           = 64;
    localparam int OUT_HANDLE_W    = 32;
    localparam int SEQ_W           = 32;
    localparam int CNT_W           = 7;
    localparam int OP_W            = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INSERT, ST_RM_RD, ST_RM_CHK, ST_MIN_RD, ST_MIN_CHK,
        ST_SEL_RD, ST_SEL_CHK, ST_SEL_EMIT, ST_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cap;        // capture input beat
        logic do_insert;
        logic do_clear;
        logic scan_init;  // scan index and accumulators reset
        logic scan_rd;    // issue read at scan index
        logic rm_step;    // evaluate remove on read data
        logic min_step;
        logic sel_step;
        logic sel_pick;   // mark best entry as chosen
        logic rm_done;    // commit kept count
        logic sel_start;  // clear chosen mask
        logic res_load;   // load result register
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic       full;
        logic       scan_end;  // scan index reached fill
        logic       sel_none;  // select count capped to zero
        logic       sel_final; // picking the final select result
        logic [OP_W-1:0] op;
    } t_stat;
endpackage
`default_nettype wire

FILE: hw/rtl/key_range_table_compactor.sv
// top level of the key range table block
// Takes one operation beat at a time. Remove, min-time and select scan the
// table; each entry is read through the single registered read port of the
// table memory, so a scan visits each stored entry in a read state and then a
// check state. A result that is not taken holds the sequencer in its result
// step until the output register frees; a taken result lets the next beat in
// while it waits on the output.
`default_nettype none
module key_range_table_compactor #(
    parameter int DEPTH       = krtc_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = krtc_pkg::HANDLE_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // operation, range_low, range_high, stamp, entry_handle, select_count
    input  wire [239:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_handle, sequence_number, entries_stored, removed_count, oldest_stamp, overflow
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [0:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    krtc_pkg::t_ctrl ctrl;
    krtc_pkg::t_stat stat;
    logic [143:0] res;
    logic [3:0] r_level;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_level <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0) r_level <= pwdata[3:0];
    end
    assign prdata = (paddr == 1'b0) ? {28'd0, r_level} : 32'd0;

    krtc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .i_stat(stat), .o_ctrl(ctrl)
    );

    krtc_datapath #(.DEPTH(DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_op(s_axis_tdata[2:0]), .i_lo(s_axis_tdata[66:3]),
        .i_hi(s_axis_tdata[130:67]), .i_stamp(s_axis_tdata[194:131]),
        .i_handle(s_axis_tdata[226:195]), .i_count(s_axis_tdata[233:227]),
        .o_res(res)
    );

    assign m_axis_tdata = {1'b0, res[142:0]};
    assign m_axis_tlast = res[143];
endmodule
`default_nettype wire

FILE: hw/rtl/krtc_ram.sv
// generic single port write, single port registered read ram
`default_nettype none
module krtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/krtc_datapath.sv
// table storage, scan accumulators and result register
`default_nettype none
module krtc_datapath #(
    parameter int DEPTH       = krtc_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = krtc_pkg::HANDLE_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  krtc_pkg::t_ctrl   i_ctrl,
    output krtc_pkg::t_stat   o_stat,
    input  wire [2:0]         i_op,
    input  wire [63:0]        i_lo,
    input  wire [63:0]        i_hi,
    input  wire [63:0]        i_stamp,
    input  wire [31:0]        i_handle,
    input  wire [6:0]         i_count,
    output logic [143:0]      o_res
);
    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int DW = 64 + 64 + 64 + HANDLE_BITS;

    logic [2:0]  r_op;
    logic [63:0] r_lo, r_hi, r_stamp;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [6:0]  r_count;
    logic [FW-1:0] r_fill, r_scan, r_kept, r_emitted, r_best;
    logic [31:0] r_seq, r_out_handle;
    logic [63:0] r_min, r_best_stamp, r_best_lo;
    logic        r_found;
    logic [DEPTH-1:0] r_chosen;
    logic [6:0]  r_removed;
    logic [143:0] r_res, n_res;

    logic         we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [63:0]  rd_lo, rd_hi, rd_st;
    logic [HANDLE_BITS-1:0] rd_h;
    logic [FW-1:0] cnt_cap;
    logic         hit, better;
    logic [AW-1:0] rs;

    krtc_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rs    = r_scan[AW-1:0];
    assign raddr = rs;
    assign {rd_h, rd_st, rd_hi, rd_lo} = rdata;
    assign hit = !(r_hi < rd_lo) && !(r_lo > rd_hi);
    assign better = !r_found || (rd_st < r_best_stamp) ||
                    (rd_st == r_best_stamp && rd_lo < r_best_lo);
    assign cnt_cap = (r_count > 7'(r_fill)) ? r_fill : FW'(r_count);

    always_comb begin
        we = 1'b0;
        waddr = r_fill[AW-1:0];
        wdata = {r_handle, r_stamp, r_hi, r_lo};
        if (i_ctrl.do_insert) begin
            we = 1'b1;
        end else if (i_ctrl.rm_step && !hit) begin
            we = 1'b1;
            waddr = r_kept[AW-1:0];
            wdata = rdata;
        end
    end

    assign o_stat.full      = (r_fill == FW'(DEPTH));
    assign o_stat.scan_end  = (r_scan == r_fill);
    assign o_stat.sel_none  = (cnt_cap == '0);
    assign o_stat.sel_final = (r_emitted + FW'(1) == cnt_cap);
    assign o_stat.op        = r_op;
    assign o_res = r_res;

    // result beat: handle, sequence, stored, removed, oldest, overflow, last
    always_comb begin
        n_res = '0;
        n_res[143] = 1'b1;
        n_res[70:64] = 7'(r_fill);
        unique case (r_op)
            krtc_pkg::OP_INSERT: begin
                n_res[142] = o_stat.full;
                n_res[63:32] = o_stat.full ? 32'd0 : r_seq;
                n_res[70:64] = o_stat.full ? 7'(r_fill) : 7'(r_fill + FW'(1));
            end
            krtc_pkg::OP_REMOVE: begin
                n_res[77:71] = r_removed;
                n_res[70:64] = 7'(r_kept);
            end
            krtc_pkg::OP_CLEAR: begin
                n_res[77:71] = 7'(r_fill);
                n_res[70:64] = '0;
            end
            krtc_pkg::OP_MIN:    n_res[141:78] = r_min;
            default: begin
                n_res[31:0] = r_out_handle;
                n_res[143] = o_stat.sel_final;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap) begin
            r_op <= i_op; r_lo <= i_lo; r_hi <= i_hi; r_stamp <= i_stamp;
            r_handle <= HANDLE_BITS'(i_handle); r_count <= i_count;
        end
        if (i_ctrl.scan_init) begin
            r_scan <= '0; r_kept <= '0; r_min <= '1; r_found <= 1'b0;
            r_removed <= '0;
        end
        if (i_ctrl.rm_step) begin
            r_scan <= r_scan + FW'(1);
            if (hit) r_removed <= r_removed + 7'd1;
            else     r_kept <= r_kept + FW'(1);
        end
        if (i_ctrl.min_step) begin
            r_scan <= r_scan + FW'(1);
            if (rd_st < r_min) r_min <= rd_st;
        end
        if (i_ctrl.sel_step) begin
            r_scan <= r_scan + FW'(1);
            if (!r_chosen[rs] && better) begin
                r_found <= 1'b1; r_best <= r_scan; r_best_stamp <= rd_st;
                r_best_lo <= rd_lo; r_out_handle <= 32'(rd_h);
            end
        end
        if (i_ctrl.res_load) begin
            r_res <= n_res;
        end
        if (i_ctrl.sel_start) begin
            r_emitted <= '0;
        end else if (i_ctrl.res_load && r_op == krtc_pkg::OP_SELECT) begin
            r_emitted <= r_emitted + FW'(1);
        end
        if (!i_rst_n) begin
            r_fill <= '0; r_seq <= '0; r_chosen <= '0;
        end else begin
            if (i_ctrl.do_insert) begin
                r_fill <= r_fill + FW'(1); r_seq <= r_seq + 32'd1;
            end
            if (i_ctrl.do_clear) r_fill <= '0;
            if (i_ctrl.rm_done)  r_fill <= r_kept;
            if (i_ctrl.sel_start) r_chosen <= '0;
            if (i_ctrl.sel_pick)  r_chosen[r_best[AW-1:0]] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/krtc_ctrl.sv
// operation sequencer for the key range table block
`default_nettype none
`include "key_range_table_compactor_macros.svh"
module krtc_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  krtc_pkg::t_stat i_stat,
    output krtc_pkg::t_ctrl o_ctrl
);
    krtc_pkg::t_state r_state, n_state;
    logic r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krtc_pkg::ST_IDLE; r_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;
    logic free;
    assign free = !r_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_out_ready;
        o_ctrl = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            krtc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.cap = 1'b1; o_ctrl.scan_init = 1'b1;
                    n_state = krtc_pkg::ST_INSERT;
                end
            end
            krtc_pkg::ST_INSERT: begin
                unique case (i_stat.op)
                    krtc_pkg::OP_INSERT, krtc_pkg::OP_CLEAR:
                        n_state = krtc_pkg::ST_RESULT;
                    krtc_pkg::OP_REMOVE: n_state = krtc_pkg::ST_RM_RD;
                    krtc_pkg::OP_MIN:    n_state = krtc_pkg::ST_MIN_RD;
                    krtc_pkg::OP_SELECT: begin
                        o_ctrl.sel_start = 1'b1;
                        n_state = krtc_pkg::ST_SEL_RD;
                    end
                    default: n_state = krtc_pkg::ST_IDLE;
                endcase
            end
            krtc_pkg::ST_RM_RD:
                n_state = i_stat.scan_end ? krtc_pkg::ST_RESULT : krtc_pkg::ST_RM_CHK;
            krtc_pkg::ST_RM_CHK: begin
                o_ctrl.rm_step = 1'b1; n_state = krtc_pkg::ST_RM_RD;
            end
            krtc_pkg::ST_MIN_RD:
                n_state = i_stat.scan_end ? krtc_pkg::ST_RESULT : krtc_pkg::ST_MIN_CHK;
            krtc_pkg::ST_MIN_CHK: begin
                o_ctrl.min_step = 1'b1; n_state = krtc_pkg::ST_MIN_RD;
            end
            krtc_pkg::ST_SEL_RD: begin
                if (i_stat.sel_none) n_state = krtc_pkg::ST_IDLE;
                else if (i_stat.scan_end) n_state = krtc_pkg::ST_SEL_EMIT;
                else n_state = krtc_pkg::ST_SEL_CHK;
            end
            krtc_pkg::ST_SEL_CHK: begin
                o_ctrl.sel_step = 1'b1; n_state = krtc_pkg::ST_SEL_RD;
            end
            krtc_pkg::ST_SEL_EMIT: begin
                if (free) begin
                    o_ctrl.res_load = 1'b1; o_ctrl.sel_pick = 1'b1;
                    o_ctrl.scan_init = 1'b1; n_valid = 1'b1;
                    n_state = i_stat.sel_final ? krtc_pkg::ST_IDLE
                                               : krtc_pkg::ST_SEL_RD;
                end
            end
            krtc_pkg::ST_RESULT: begin
                if (free) begin
                    o_ctrl.res_load = 1'b1; n_valid = 1'b1;
                    o_ctrl.do_insert = (i_stat.op == krtc_pkg::OP_INSERT) && !i_stat.full;
                    o_ctrl.do_clear = (i_stat.op == krtc_pkg::OP_CLEAR);
                    o_ctrl.rm_done = (i_stat.op == krtc_pkg::OP_REMOVE);
                    n_state = krtc_pkg::ST_IDLE;
                end
            end
            default: n_state = krtc_pkg::ST_IDLE;
        endcase
    end

    `KRT_ASSERT(a_load_free, i_clk, i_rst_n, o_ctrl.res_load |-> (!r_valid || i_out_ready))
    `KRT_ASSERT(a_in_idle, i_clk, i_rst_n, o_in_ready |-> (r_state == krtc_pkg::ST_IDLE))
    `KRT_ASSERT(a_load_valid, i_clk, i_rst_n, o_ctrl.res_load |=> r_valid)
endmodule
`default_nettype wire
